FILE: rtl/piecewise_linear_interpolator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the piecewise linear interpolator
// Concurrent assertion shorthands clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_UNIT_ASSERT_SVH

// Same-cycle implication
`define PLI_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pli assertion failed");

// Next-cycle implication
`define PLI_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pli assertion failed");

`endif

FILE: rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Shared widths, status codes and types of the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

    localparam int VAL_W   = 32;   // Q16.16 value width
    localparam int IDX_W   = 9;    // breakpoint index width on the ports
    localparam int NUM_W   = 10;   // point count register width
    localparam int ST_W    = 2;    // status width
    localparam int DIFF_W  = VAL_W + 1;
    localparam int FRAC_W  = 16;
    localparam int NUMER_W = DIFF_W + FRAC_W;  // scaled dividend magnitude
    localparam int PROD_W  = 64;
    localparam int CNT_W   = 6;
    localparam int DIV_STEPS = NUMER_W;
    localparam int MUL_STEPS = VAL_W;

    localparam logic [NUM_W-1:0] NUM_POINTS_RST = NUM_W'(2);

    typedef logic [ST_W-1:0] status_t;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_ZERO_WIDTH = 2'd1;
    localparam status_t ST_SAT        = 2'd2;

    // One breakpoint as stored in the table
    typedef struct packed {
        logic signed [VAL_W-1:0] x;
        logic signed [VAL_W-1:0] y;
    } entry_t;

    // Segment handed from the scan to the arithmetic unit
    typedef struct packed {
        logic                    start;
        logic signed [VAL_W-1:0] qx;
        logic signed [VAL_W-1:0] x0;
        logic signed [VAL_W-1:0] x1;
        logic signed [VAL_W-1:0] y0;
        logic signed [VAL_W-1:0] y1;
    } seg_t;

    // Result returned by the arithmetic unit
    typedef struct packed {
        logic                    done;
        logic signed [VAL_W-1:0] result;
        status_t                 status;
    } arith_rsp_t;

endpackage

FILE: rtl/pli_req_if.sv
// ----------------------------------------------------------------------------
// pli_req_if
// Request channel: breakpoint writes and interpolation queries.
// ----------------------------------------------------------------------------
interface pli_req_if
    import pli_pkg::*;
    ();

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [IDX_W-1:0]        point_index;
    logic signed [VAL_W-1:0] x_value;
    logic signed [VAL_W-1:0] y_value;

    modport source (
        output valid, req_type, point_index, x_value, y_value,
        input  ready
    );

    modport sink (
        input  valid, req_type, point_index, x_value, y_value,
        output ready
    );

endinterface

FILE: rtl/pli_rsp_if.sv
// ----------------------------------------------------------------------------
// pli_rsp_if
// Response channel: interpolated value, segment and status per query.
// ----------------------------------------------------------------------------
interface pli_rsp_if
    import pli_pkg::*;
    ();

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] result_value;
    logic [IDX_W-1:0]        segment_index;
    status_t                 status;

    modport source (
        output valid, result_value, segment_index, status,
        input  ready
    );

    modport sink (
        input  valid, result_value, segment_index, status,
        output ready
    );

endinterface

FILE: rtl/pli_table.sv
// ----------------------------------------------------------------------------
// pli_table
// Breakpoint memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pli_table
    import pli_pkg::*;
#(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write one breakpoint
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read every cycle; the read data is registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pli_arith.sv
// ----------------------------------------------------------------------------
// pli_arith
// Bit-serial interpolation datapath: restoring divide for the Q16.16
// fraction, shift-add multiply by the segment rise, then add and saturate.
// ----------------------------------------------------------------------------
module pli_arith
    import pli_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  seg_t       seg,
    output arith_rsp_t rsp
);

    typedef enum logic [2:0] {
        A_IDLE,
        A_SETUP,
        A_DIV,
        A_CLAMP,
        A_MUL,
        A_NEG,
        A_ADD,
        A_DONE
    } astate_t;

    astate_t                  state_reg;
    logic signed [DIFF_W-1:0] dx_reg;
    logic signed [DIFF_W-1:0] w_reg;
    logic signed [DIFF_W-1:0] dy_reg;
    logic signed [VAL_W-1:0]  y0_reg;
    logic [DIFF_W-1:0]        den_reg;
    logic [DIFF_W-1:0]        rem_reg;
    logic [NUMER_W-1:0]       quo_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     neg_q_reg;
    logic                     neg_p_reg;
    logic                     sat_reg;
    logic [PROD_W-1:0]        acc_reg;
    logic [PROD_W-1:0]        mcand_reg;
    logic [VAL_W-1:0]         mplier_reg;
    logic [NUMER_W-1:0]       p_reg;
    logic signed [VAL_W-1:0]  result_reg;
    status_t                  status_reg;

    logic [DIFF_W-1:0]        dx_mag;
    logic [DIFF_W-1:0]        w_mag;
    logic [DIFF_W-1:0]        dy_mag;
    logic [DIFF_W:0]          rem_shift;
    logic                     rem_ge;
    logic [PROD_W-FRAC_W-1:0] p_trunc;
    logic [NUMER_W:0]         sum;
    logic                     sum_hi;
    logic                     sum_lo;

    // Magnitudes of the differences
    always_comb
    begin
        dx_mag = dx_reg[DIFF_W-1] ? DIFF_W'(-dx_reg) : DIFF_W'(dx_reg);
        w_mag  = w_reg[DIFF_W-1]  ? DIFF_W'(-w_reg)  : DIFF_W'(w_reg);
        dy_mag = dy_reg[DIFF_W-1] ? DIFF_W'(-dy_reg) : DIFF_W'(dy_reg);
    end

    // One restoring divide step
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[NUMER_W-1]};
        rem_ge    = (rem_shift >= {1'b0, den_reg});
    end

    // Truncate the product toward zero and add to the left ordinate
    always_comb
    begin
        p_trunc = acc_reg[PROD_W-1:FRAC_W];
        sum     = {{(NUMER_W-VAL_W+1){y0_reg[VAL_W-1]}}, y0_reg}
                + {p_reg[NUMER_W-1], p_reg};
        sum_hi  = !sum[NUMER_W] && (sum[NUMER_W-1:VAL_W-1] != '0);
        sum_lo  = sum[NUMER_W] && (sum[NUMER_W-1:VAL_W-1] != '1);
    end

    // Sequencer and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= A_IDLE;
            dx_reg     <= '0;
            w_reg      <= '0;
            dy_reg     <= '0;
            y0_reg     <= '0;
            den_reg    <= '0;
            rem_reg    <= '0;
            quo_reg    <= '0;
            cnt_reg    <= '0;
            neg_q_reg  <= 1'b0;
            neg_p_reg  <= 1'b0;
            sat_reg    <= 1'b0;
            acc_reg    <= '0;
            mcand_reg  <= '0;
            mplier_reg <= '0;
            p_reg      <= '0;
            result_reg <= '0;
            status_reg <= ST_OK;
        end
        else
        begin
            unique case (state_reg)
                A_IDLE:
                begin
                    if (seg.start)
                    begin
                        dx_reg    <= {seg.qx[VAL_W-1], seg.qx} - {seg.x0[VAL_W-1], seg.x0};
                        w_reg     <= {seg.x1[VAL_W-1], seg.x1} - {seg.x0[VAL_W-1], seg.x0};
                        dy_reg    <= {seg.y1[VAL_W-1], seg.y1} - {seg.y0[VAL_W-1], seg.y0};
                        y0_reg    <= seg.y0;
                        sat_reg   <= 1'b0;
                        state_reg <= A_SETUP;
                    end
                end
                A_SETUP:
                begin
                    if (w_reg == '0)
                    begin
                        result_reg <= y0_reg;
                        status_reg <= ST_ZERO_WIDTH;
                        state_reg  <= A_DONE;
                    end
                    else
                    begin
                        quo_reg   <= {dx_mag, {FRAC_W{1'b0}}};
                        den_reg   <= w_mag;
                        rem_reg   <= '0;
                        neg_q_reg <= dx_reg[DIFF_W-1] ^ w_reg[DIFF_W-1];
                        neg_p_reg <= dx_reg[DIFF_W-1] ^ w_reg[DIFF_W-1] ^ dy_reg[DIFF_W-1];
                        mcand_reg <= PROD_W'(dy_mag);
                        cnt_reg   <= '0;
                        state_reg <= A_DIV;
                    end
                end
                A_DIV:
                begin
                    rem_reg <= rem_ge ? DIFF_W'(rem_shift - {1'b0, den_reg})
                                      : rem_shift[DIFF_W-1:0];
                    quo_reg <= {quo_reg[NUMER_W-2:0], rem_ge};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        state_reg <= A_CLAMP;
                    end
                end
                A_CLAMP:
                begin
                    // Clamp the fraction to the signed 32-bit range
                    if (neg_q_reg && (quo_reg > NUMER_W'(64'h8000_0000)))
                    begin
                        mplier_reg <= 32'h8000_0000;
                        sat_reg    <= 1'b1;
                    end
                    else if (!neg_q_reg && (quo_reg > NUMER_W'(64'h7FFF_FFFF)))
                    begin
                        mplier_reg <= 32'h7FFF_FFFF;
                        sat_reg    <= 1'b1;
                    end
                    else
                    begin
                        mplier_reg <= quo_reg[VAL_W-1:0];
                    end
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= A_MUL;
                end
                A_MUL:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg  <= {mcand_reg[PROD_W-2:0], 1'b0};
                    mplier_reg <= {1'b0, mplier_reg[VAL_W-1:1]};
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    begin
                        state_reg <= A_NEG;
                    end
                end
                A_NEG:
                begin
                    p_reg     <= neg_p_reg ? NUMER_W'(-{1'b0, p_trunc})
                                           : NUMER_W'({1'b0, p_trunc});
                    state_reg <= A_ADD;
                end
                A_ADD:
                begin
                    if (sum_hi)
                    begin
                        result_reg <= 32'sh7FFF_FFFF;
                    end
                    else if (sum_lo)
                    begin
                        result_reg <= 32'sh8000_0000;
                    end
                    else
                    begin
                        result_reg <= sum[VAL_W-1:0];
                    end
                    status_reg <= (sat_reg || sum_hi || sum_lo) ? ST_SAT : ST_OK;
                    state_reg  <= A_DONE;
                end
                A_DONE:
                begin
                    state_reg <= A_IDLE;
                end
                default:
                begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

    assign rsp.done   = (state_reg == A_DONE);
    assign rsp.result = result_reg;
    assign rsp.status = status_reg;

endmodule

FILE: rtl/piecewise_linear_interpolator_unit.sv
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator_unit
// Breakpoint table with segment scan and linear interpolation in Q16.16.
// ----------------------------------------------------------------------------
// A query first scans the table: the scan reads one table entry per cycle
// through the single read port of the breakpoint memory, then the
// bit-serial unit runs the divide and then the multiply. A zero-width
// segment skips the arithmetic. Items are taken one at a time; a finished
// result waits in the output register while the next item is accepted.
// The table needs no clearing after reset; every entry a query reaches
// must have been written first.
module piecewise_linear_interpolator_unit
    import pli_pkg::*;
#(
    parameter int MAX_POINTS = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [NUM_W-1:0] cfg_wdata,
    pli_req_if.sink          req,
    pli_rsp_if.source        rsp
);

    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_PUT
    } state_t;

    state_t                  state_reg;
    logic [NUM_W-1:0]        num_points_reg;
    logic [AW-1:0]           scan_addr_reg;
    logic [AW-1:0]           data_idx_reg;
    logic signed [VAL_W-1:0] qx_reg;
    entry_t                  prev_reg;
    seg_t                    seg_reg;
    logic [AW-1:0]           k_reg;
    logic                    rsp_valid_reg;
    logic signed [VAL_W-1:0] result_reg;
    logic [IDX_W-1:0]        segment_reg;
    status_t                 status_reg;

    logic [NUM_W-1:0]        n_eff;
    logic [AW-1:0]           last_idx;
    logic                    req_xfer;
    logic                    wr_en;
    entry_t                  wdata;
    entry_t                  rdata;
    logic                    hit;
    logic                    put_fire;
    arith_rsp_t              arith_rsp;

    // Effective point count and last entry index
    always_comb
    begin
        priority if (num_points_reg < NUM_W'(2))
        begin
            n_eff = NUM_W'(2);
        end
        else if (32'(num_points_reg) > MAX_POINTS)
        begin
            n_eff = NUM_W'(MAX_POINTS);
        end
        else
        begin
            n_eff = num_points_reg;
        end
        last_idx = AW'(n_eff - 1'b1);
    end

    // Request transfer and table write
    assign req.ready = (state_reg == S_IDLE);
    assign req_xfer  = req.valid && req.ready;
    assign wr_en     = req_xfer && !req.req_type && (32'(req.point_index) < MAX_POINTS);
    assign wdata.x   = req.x_value;
    assign wdata.y   = req.y_value;

    pli_table #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(req.point_index)),
        .wdata (wdata),
        .raddr (scan_addr_reg),
        .rdata (rdata)
    );

    // Segment found: first entry at or above the query, or the last one
    assign hit = (data_idx_reg != '0)
              && ((data_idx_reg == last_idx) || (qx_reg <= rdata.x));

    // Result moves to the output register once that register is free
    assign put_fire = (state_reg == S_PUT) && (!rsp_valid_reg || rsp.ready);

    pli_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .seg   (seg_reg),
        .rsp   (arith_rsp)
    );

    // Point count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_points_reg <= NUM_POINTS_RST;
        end
        else if (cfg_we)
        begin
            num_points_reg <= cfg_wdata;
        end
    end

    // Control sequence and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_addr_reg <= '0;
            data_idx_reg  <= '0;
            qx_reg        <= '0;
            prev_reg      <= '0;
            seg_reg       <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
            result_reg    <= '0;
            segment_reg   <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            // Pulse the arithmetic start, registered from the scan finding the segment
            seg_reg.start <= (state_reg == S_SCAN) && hit;

            // Load a finished result, drop it once the consumer takes it
            if (put_fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer && req.req_type)
                    begin
                        qx_reg        <= req.x_value;
                        scan_addr_reg <= AW'(1);
                        data_idx_reg  <= '0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Advance one entry per cycle, keep the left neighbor
                    scan_addr_reg <= hit ? '0 : scan_addr_reg + 1'b1;
                    data_idx_reg  <= data_idx_reg + 1'b1;
                    prev_reg      <= rdata;
                    if (hit)
                    begin
                        seg_reg.qx    <= qx_reg;
                        seg_reg.x0    <= prev_reg.x;
                        seg_reg.y0    <= prev_reg.y;
                        seg_reg.x1    <= rdata.x;
                        seg_reg.y1    <= rdata.y;
                        k_reg         <= data_idx_reg;
                        state_reg     <= S_CALC;
                    end
                end
                S_CALC:
                begin
                    if (arith_rsp.done)
                    begin
                        state_reg <= S_PUT;
                    end
                end
                S_PUT:
                begin
                    // Hold until the output register is free
                    if (put_fire)
                    begin
                        result_reg    <= arith_rsp.result;
                        segment_reg   <= IDX_W'(k_reg);
                        status_reg    <= arith_rsp.status;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.result_value  = result_reg;
    assign rsp.segment_index = segment_reg;
    assign rsp.status        = status_reg;

endmodule

FILE: rtl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks of the interpolator: response ordering, status codes and handshake.
// ----------------------------------------------------------------------------
`include "piecewise_linear_interpolator_unit_assert.svh"

module pli_checker
    import pli_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    req_valid,
    input logic                    req_ready,
    input logic                    req_type,
    input logic                    rsp_valid,
    input logic                    rsp_ready,
    input logic signed [VAL_W-1:0] rsp_result_value,
    input logic [IDX_W-1:0]        rsp_segment_index,
    input status_t                 rsp_status
);

    logic [1:0]                   pend_reg;
    logic                         qry_xfer;
    logic                         rsp_xfer;
    logic                         status_legal;
    logic [VAL_W+IDX_W+ST_W-1:0]  rsp_payload;

    assign qry_xfer     = req_valid && req_ready && req_type;
    assign rsp_xfer     = rsp_valid && rsp_ready;
    assign status_legal = (rsp_status == ST_OK) || (rsp_status == ST_ZERO_WIDTH)
                       || (rsp_status == ST_SAT);
    assign rsp_payload  = {rsp_result_value, rsp_segment_index, rsp_status};

    // Count queries whose result has not been transferred yet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, qry_xfer} - {1'b0, rsp_xfer};
        end
    end

    `PLI_ASSERT_IMP(a_rsp_has_query, rsp_xfer, pend_reg != 2'd0)
    `PLI_ASSERT_IMP(a_ready_only_when_done, req_ready && (pend_reg != 2'd0), rsp_valid)
    `PLI_ASSERT_IMP(a_status_code, rsp_valid, status_legal)
    `PLI_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

endmodule

bind piecewise_linear_interpolator_unit pli_checker u_pli_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .req_valid         (req.valid),
    .req_ready         (req.ready),
    .req_type          (req.req_type),
    .rsp_valid         (rsp.valid),
    .rsp_ready         (rsp.ready),
    .rsp_result_value  (rsp.result_value),
    .rsp_segment_index (rsp.segment_index),
    .rsp_status        (rsp.status)
);
